### hw/rtl/mat_pkg.sv
// mat_pkg: shared types and constants of the mean adaptive threshold block
// used by mean_adaptive_threshold; no dependencies
`default_nettype none

package mat_pkg;

   localparam int unsigned PIXEL_W        = 8;
   localparam int unsigned IMAGE_WIDTH_W  = 11;
   localparam int unsigned IMAGE_HEIGHT_W = 13;
   localparam int unsigned WINDOW_SIZE_W  = 5;
   localparam int unsigned CSR_INDEX_W    = 3;
   localparam int unsigned CSR_DATA_W     = 13;

   localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 11'd640;
   localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;
   localparam logic [WINDOW_SIZE_W-1:0]  WINDOW_SIZE_RESET  = 5'd3;
   localparam logic [PIXEL_W-1:0]        MAX_VALUE_RESET    = 8'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_WINDOW_SIZE  = 3'd2,
      CSR_MAX_VALUE    = 3'd3,
      CSR_INVERT       = 3'd4
   } csr_index_type;

   typedef enum logic {
      MODE_PIXEL = 1'b0,
      MODE_DRAIN = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SUM,
      ST_TAIL,
      ST_MUL,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/mat_ram.sv
// mat_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module mat_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

### hw/rtl/mean_adaptive_threshold.sv
// mean_adaptive_threshold: streaming binary threshold against the window mean
// depends on mat_pkg and mat_ram
`default_nettype none

// Pixels enter in raster order and are written to a line store of MAX_WINDOW
// rows. Items (pixel or drain) are taken only while the sequencer is idle;
// when the window anchored at the oldest pending result position is complete,
// the sequencer reads the window from the store through its single read port,
// one pixel a cycle, into one accumulator, then compares pixel*count against
// the sum. The window is clipped to the image, so it holds up to window_size
// squared pixels (256 at the default maximum). The result waits in an output
// register, so the next item is taken while it is still stalled.
module mean_adaptive_threshold #(
   parameter int unsigned MAX_WIDTH  = 1024,
   parameter int unsigned MAX_WINDOW = 16,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_mode,
   input  wire logic [mat_pkg::PIXEL_W-1:0]         req_pixel,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [mat_pkg::PIXEL_W-1:0]         rsp_result_pixel,
   output logic                                     rsp_last_of_image,
   input  wire logic                                csr_we,
   input  wire logic [mat_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [mat_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);
   localparam int unsigned RW    = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned KW    = $clog2(MAX_WINDOW + 1);
   localparam int unsigned DW    = $clog2(MAX_WINDOW);
   localparam int unsigned DEPTH = MAX_WIDTH * MAX_WINDOW;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned SW    = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
   localparam int unsigned NW    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
   localparam int unsigned PW    = mat_pkg::PIXEL_W + NW;

   // configuration
   logic [mat_pkg::IMAGE_WIDTH_W-1:0]  image_width_ff;
   logic [mat_pkg::IMAGE_HEIGHT_W-1:0] image_height_ff;
   logic [mat_pkg::WINDOW_SIZE_W-1:0]  window_size_ff;
   logic [mat_pkg::PIXEL_W-1:0]        max_value_ff;
   logic                               invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= mat_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= mat_pkg::IMAGE_HEIGHT_RESET;
         window_size_ff  <= mat_pkg::WINDOW_SIZE_RESET;
         max_value_ff    <= mat_pkg::MAX_VALUE_RESET;
         invert_ff       <= 1'b0;
      end else if (csr_we) begin
         unique case (mat_pkg::csr_index_type'(csr_index))
            mat_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[mat_pkg::IMAGE_WIDTH_W-1:0];
            mat_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            mat_pkg::CSR_WINDOW_SIZE:  window_size_ff  <= csr_wdata[mat_pkg::WINDOW_SIZE_W-1:0];
            mat_pkg::CSR_MAX_VALUE:    max_value_ff    <= csr_wdata[mat_pkg::PIXEL_W-1:0];
            mat_pkg::CSR_INVERT:       invert_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // saturated sizes
   logic [CW-1:0] w_cl;
   logic [RW-1:0] h_cl;
   logic [KW-1:0] k_cl;

   always_comb begin
      if (image_width_ff == '0) begin
         w_cl = CW'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         w_cl = CW'(MAX_WIDTH);
      end else begin
         w_cl = CW'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         h_cl = RW'(1);
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         h_cl = RW'(MAX_HEIGHT);
      end else begin
         h_cl = RW'(image_height_ff);
      end
      if (window_size_ff == '0) begin
         k_cl = KW'(1);
      end else if (32'(window_size_ff) > MAX_WINDOW) begin
         k_cl = KW'(MAX_WINDOW);
      end else begin
         k_cl = KW'(window_size_ff);
      end
   end

   function automatic logic [AW-1:0] store_addr(input logic [DW-1:0] slot,
                                                input logic [CW-1:0] col);
      store_addr = AW'(32'(slot) * MAX_WIDTH + 32'(col));
   endfunction

   // state
   mat_pkg::state_type state_ff, state_in;

   logic [RW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [DW-1:0] in_slot_ff, in_slot_in;
   logic          in_full_ff, in_full_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [DW-1:0] out_slot_ff, out_slot_in;

   logic [DW-1:0] dr_ff, dr_in, dc_ff, dc_in;
   logic [DW-1:0] dr_last_ff, dr_last_in, dc_last_ff, dc_last_in;
   logic [DW-1:0] sweep_slot_ff, sweep_slot_in;
   logic [CW-1:0] sweep_col_ff, sweep_col_in;
   logic          rd_valid_ff, rd_valid_in, rd_first_ff, rd_first_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [mat_pkg::PIXEL_W-1:0] pix_ff, pix_in;
   logic [PW-1:0] prod_ff, prod_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [mat_pkg::PIXEL_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic          req_take;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [mat_pkg::PIXEL_W-1:0] ram_rdata;

   // window extent and readiness
   logic [RW:0] rr_sum, rr_lim, rr;
   logic [CW:0] cc_sum, cc_lim, cc;
   logic        win_ready;
   logic        emit_ok, is_last, sweep_end;

   always_comb begin
      rr_sum = {1'b0, out_row_ff} + (RW+1)'(k_cl) - (RW+1)'(1);
      rr_lim = {1'b0, h_cl} - (RW+1)'(1);
      rr     = (rr_sum > rr_lim) ? rr_lim : rr_sum;
      if (rr < {1'b0, out_row_ff}) begin
         rr = {1'b0, out_row_ff};
      end
      cc_sum = {1'b0, out_col_ff} + (CW+1)'(k_cl) - (CW+1)'(1);
      cc_lim = {1'b0, w_cl} - (CW+1)'(1);
      cc     = (cc_sum > cc_lim) ? cc_lim : cc_sum;
      if (cc < {1'b0, out_col_ff}) begin
         cc = {1'b0, out_col_ff};
      end
      win_ready = in_full_ff || ({1'b0, in_row_ff} > rr)
                  || (({1'b0, in_row_ff} == rr) && ({1'b0, in_col_ff} > cc));
      is_last   = ((RW+1)'(out_row_ff) + (RW+1)'(1) >= (RW+1)'(h_cl))
                  && ((CW+1)'(out_col_ff) + (CW+1)'(1) >= (CW+1)'(w_cl));
      emit_ok   = !rsp_valid_ff || !rsp_stall;
      sweep_end = (dc_ff == dc_last_ff) && (dr_ff == dr_last_ff);
   end

   assign req_stall = (state_ff != mat_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mat_pkg::ST_IDLE:  if (req_take) state_in = mat_pkg::ST_CHECK;
         mat_pkg::ST_CHECK: state_in = win_ready ? mat_pkg::ST_SUM : mat_pkg::ST_IDLE;
         mat_pkg::ST_SUM:   if (sweep_end) state_in = mat_pkg::ST_TAIL;
         mat_pkg::ST_TAIL:  state_in = mat_pkg::ST_MUL;
         mat_pkg::ST_MUL:   state_in = mat_pkg::ST_EMIT;
         mat_pkg::ST_EMIT:  if (emit_ok) state_in = mat_pkg::ST_IDLE;
         default:           state_in = mat_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      in_row_in     = in_row_ff;
      in_col_in     = in_col_ff;
      in_slot_in    = in_slot_ff;
      in_full_in    = in_full_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      out_slot_in   = out_slot_ff;
      dr_in         = dr_ff;
      dc_in         = dc_ff;
      dr_last_in    = dr_last_ff;
      dc_last_in    = dc_last_ff;
      sweep_slot_in = sweep_slot_ff;
      sweep_col_in  = sweep_col_ff;
      rd_valid_in   = 1'b0;
      rd_first_in   = 1'b0;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      pix_in        = pix_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = store_addr(in_slot_ff, in_col_ff);
      ram_raddr     = store_addr(sweep_slot_ff, sweep_col_ff);

      // accumulator, fed from the registered store read
      if (rd_valid_ff) begin
         sum_in = sum_ff + SW'(ram_rdata);
         cnt_in = cnt_ff + NW'(1);
         if (rd_first_ff) begin
            pix_in = ram_rdata;
         end
      end

      unique case (state_ff)
         mat_pkg::ST_IDLE: begin
            if (req_take && (mat_pkg::mode_type'(req_mode) == mat_pkg::MODE_PIXEL)
                && !in_full_ff) begin
               ram_we = 1'b1;
               if ((CW+1)'(in_col_ff) + (CW+1)'(1) >= (CW+1)'(w_cl)) begin
                  in_col_in = '0;
                  if ((RW+1)'(in_row_ff) + (RW+1)'(1) >= (RW+1)'(h_cl)) begin
                     in_row_in  = '0;
                     in_slot_in = '0;
                     in_full_in = 1'b1;
                  end else begin
                     in_row_in  = in_row_ff + RW'(1);
                     in_slot_in = (32'(in_slot_ff) == MAX_WINDOW - 1) ? '0
                                  : in_slot_ff + DW'(1);
                  end
               end else begin
                  in_col_in = in_col_ff + CW'(1);
               end
            end
         end
         mat_pkg::ST_CHECK: begin
            dr_in         = '0;
            dc_in         = '0;
            dr_last_in    = DW'(rr - {1'b0, out_row_ff});
            dc_last_in    = DW'(cc - {1'b0, out_col_ff});
            sweep_slot_in = out_slot_ff;
            sweep_col_in  = out_col_ff;
            sum_in        = '0;
            cnt_in        = '0;
         end
         mat_pkg::ST_SUM: begin
            rd_valid_in = 1'b1;
            rd_first_in = (dr_ff == '0) && (dc_ff == '0);
            if (dc_ff == dc_last_ff) begin
               dc_in        = '0;
               sweep_col_in = out_col_ff;
               dr_in        = dr_ff + DW'(1);
               sweep_slot_in = (32'(sweep_slot_ff) == MAX_WINDOW - 1) ? '0
                               : sweep_slot_ff + DW'(1);
            end else begin
               dc_in        = dc_ff + DW'(1);
               sweep_col_in = sweep_col_ff + CW'(1);
            end
         end
         mat_pkg::ST_TAIL: ;
         mat_pkg::ST_MUL: begin
            // pixel > floor(sum / n)  is the same as  sum < pixel * n
            prod_in = PW'(pix_ff) * PW'(cnt_ff);
         end
         mat_pkg::ST_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = ((SW'(sum_ff) < prod_ff) ^ invert_ff) ? max_value_ff : '0;
               rsp_last_in  = is_last;
               if (is_last) begin
                  in_row_in   = '0;
                  in_col_in   = '0;
                  in_slot_in  = '0;
                  in_full_in  = 1'b0;
                  out_row_in  = '0;
                  out_col_in  = '0;
                  out_slot_in = '0;
               end else if ((CW+1)'(out_col_ff) + (CW+1)'(1) >= (CW+1)'(w_cl)) begin
                  out_col_in  = '0;
                  out_row_in  = out_row_ff + RW'(1);
                  out_slot_in = (32'(out_slot_ff) == MAX_WINDOW - 1) ? '0
                                : out_slot_ff + DW'(1);
               end else begin
                  out_col_in = out_col_ff + CW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mat_pkg::ST_IDLE;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_slot_ff   <= '0;
         in_full_ff   <= 1'b0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_slot_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         in_slot_ff   <= in_slot_in;
         in_full_ff   <= in_full_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         out_slot_ff  <= out_slot_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      dr_ff         <= dr_in;
      dc_ff         <= dc_in;
      dr_last_ff    <= dr_last_in;
      dc_last_ff    <= dc_last_in;
      sweep_slot_ff <= sweep_slot_in;
      sweep_col_ff  <= sweep_col_in;
      rd_first_ff   <= rd_first_in;
      sum_ff        <= sum_in;
      pix_ff        <= pix_in;
      prod_ff       <= prod_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_last_ff   <= rsp_last_in;
   end

   mat_ram #(
      .WIDTH (mat_pkg::PIXEL_W),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_pixel),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_pixel  = rsp_pixel_ff;
   assign rsp_last_of_image = rsp_last_ff;

   // store writes only happen while an item is taken
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == mat_pkg::ST_IDLE) && req_valid)
      else $error("line store written outside item acceptance");

   // window never holds more pixels than the largest window
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= MAX_WINDOW * MAX_WINDOW)
      else $error("window pixel count out of range");

   // a fresh result is zero or the bright value
   a_rsp_value: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mat_pkg::ST_EMIT) && emit_ok
      |=> rsp_valid && (rsp_result_pixel == '0 || rsp_result_pixel == $past(max_value_ff)))
      else $error("result value is neither zero nor max value");

   // reads are only in flight during the sweep and its tail
   a_read_window: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == mat_pkg::ST_SUM) || (state_ff == mat_pkg::ST_TAIL))
      else $error("store read outside window sweep");

endmodule

`default_nettype wire

### verif/mean_adaptive_threshold_tb.sv
// mean_adaptive_threshold_tb: self-checking testbench for mean_adaptive_threshold
// keeps its own threshold predictor and result queue; depends on mat_pkg and the rtl
`default_nettype none

module mean_adaptive_threshold_tb;

   localparam int unsigned STORE_ROWS = 16;
   localparam int unsigned STORE_COLS = 1024;
   localparam int unsigned HEIGHT_CAP = 4096;
   localparam int unsigned SETTLE_CYCLES = 300;
   localparam logic [mat_pkg::CSR_INDEX_W-1:0] CSR_LAST_INDEX = '1;

   typedef struct packed {
      logic [mat_pkg::PIXEL_W-1:0] level;
      logic                        last;
   } threshold_result_type;

   logic                            clock, reset;
   logic                            req_valid, req_stall, req_mode;
   logic [mat_pkg::PIXEL_W-1:0]     req_pixel;
   logic                            rsp_valid, rsp_stall, rsp_last_of_image;
   logic [mat_pkg::PIXEL_W-1:0]     rsp_result_pixel;
   logic                            csr_we;
   logic [mat_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [mat_pkg::CSR_DATA_W-1:0]  csr_wdata;

   mean_adaptive_threshold dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_pixel(rsp_result_pixel), .rsp_last_of_image(rsp_last_of_image),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor copy of the block
   logic [mat_pkg::PIXEL_W-1:0]        pic_store [STORE_ROWS*STORE_COLS];
   int unsigned                        wr_row, wr_col, rd_row, rd_col;
   bit                                 frame_in_done;
   logic [mat_pkg::IMAGE_WIDTH_W-1:0]  cfg_width;
   logic [mat_pkg::IMAGE_HEIGHT_W-1:0] cfg_height;
   logic [mat_pkg::WINDOW_SIZE_W-1:0]  cfg_window;
   logic [mat_pkg::PIXEL_W-1:0]        cfg_max;
   logic                               cfg_invert;

   threshold_result_type expected_results[$];
   int unsigned mismatches, failures, items_sent, results_seen, images_done;
   int unsigned hold_left;
   bit          quiet;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 4_000_000);
      $display("timeout with %0d results still expected", expected_results.size());
      $display("TEST FAILED");
      $finish;
   end

   function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int unsigned store_at(int unsigned r, int unsigned c);
      return (r % STORE_ROWS) * STORE_COLS + (c % STORE_COLS);
   endfunction

   function automatic logic [mat_pkg::PIXEL_W-1:0] rand_pixel();
      return mat_pkg::PIXEL_W'($urandom_range(255));
   endfunction

   task automatic predict_threshold(input mat_pkg::mode_type m,
                                    input logic [mat_pkg::PIXEL_W-1:0] px);
      int unsigned w, h, k, r_end, c_end, sum, cnt, mean;
      bit ready, bright, last;
      threshold_result_type res;
      w = clip(cfg_width, 1, STORE_COLS);
      h = clip(cfg_height, 1, HEIGHT_CAP);
      k = clip(cfg_window, 1, STORE_ROWS);
      // pixels after a full image behave as drain items
      if (m == mat_pkg::MODE_PIXEL && !frame_in_done) begin
         pic_store[store_at(wr_row, wr_col)] = px;
         wr_col++;
         if (wr_col >= w) begin
            wr_col = 0;
            wr_row++;
            if (wr_row >= h) begin
               wr_row = 0;
               frame_in_done = 1;
            end
         end
      end
      r_end = rd_row + k - 1;
      if (r_end > h - 1) r_end = h - 1;
      if (r_end < rd_row) r_end = rd_row;
      c_end = rd_col + k - 1;
      if (c_end > w - 1) c_end = w - 1;
      if (c_end < rd_col) c_end = rd_col;
      ready = frame_in_done || wr_row > r_end || (wr_row == r_end && wr_col > c_end);
      if (!ready) return;
      sum = 0;
      for (int unsigned r = rd_row; r <= r_end; r++)
         for (int unsigned c = rd_col; c <= c_end; c++)
            sum += pic_store[store_at(r, c)];
      cnt = (r_end - rd_row + 1) * (c_end - rd_col + 1);
      mean = sum / cnt;
      bright = pic_store[store_at(rd_row, rd_col)] > mean;
      if (cfg_invert) bright = !bright;
      last = (rd_row + 1 >= h) && (rd_col + 1 >= w);
      res.level = bright ? cfg_max : '0;
      res.last = last;
      expected_results.push_back(res);
      if (last) begin
         wr_row = 0; wr_col = 0; rd_row = 0; rd_col = 0;
         frame_in_done = 0;
         images_done++;
      end else begin
         rd_col++;
         if (rd_col >= w) begin
            rd_col = 0;
            rd_row++;
         end
      end
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet) return 0;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   task automatic send_item(input mat_pkg::mode_type m,
                            input logic [mat_pkg::PIXEL_W-1:0] px);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode  <= m;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
      predict_threshold(m, px);
      items_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mat_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [mat_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock) csr_we <= 1'b0;
      case (idx)
         mat_pkg::CSR_IMAGE_WIDTH:  cfg_width  = value[mat_pkg::IMAGE_WIDTH_W-1:0];
         mat_pkg::CSR_IMAGE_HEIGHT: cfg_height = value[mat_pkg::IMAGE_HEIGHT_W-1:0];
         mat_pkg::CSR_WINDOW_SIZE:  cfg_window = value[mat_pkg::WINDOW_SIZE_W-1:0];
         mat_pkg::CSR_MAX_VALUE:    cfg_max    = value[mat_pkg::PIXEL_W-1:0];
         mat_pkg::CSR_INVERT:       cfg_invert = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(input int unsigned w, input int unsigned h, input int unsigned k,
                            input int unsigned mx, input int unsigned inv);
      write_reg(mat_pkg::CSR_IMAGE_WIDTH, mat_pkg::CSR_DATA_W'(w));
      write_reg(mat_pkg::CSR_IMAGE_HEIGHT, mat_pkg::CSR_DATA_W'(h));
      write_reg(mat_pkg::CSR_WINDOW_SIZE, mat_pkg::CSR_DATA_W'(k));
      write_reg(mat_pkg::CSR_MAX_VALUE, mat_pkg::CSR_DATA_W'(mx));
      write_reg(mat_pkg::CSR_INVERT, mat_pkg::CSR_DATA_W'(inv));
   endtask

   // style 0 uniform, 1 low contrast around a base, 2 only the extremes
   function automatic logic [mat_pkg::PIXEL_W-1:0] make_pixel(int unsigned style,
                                                             int unsigned base);
      case (style)
         0: return rand_pixel();
         1: return mat_pkg::PIXEL_W'(clip(base + $urandom_range(4), 2, 257) - 2);
         default: return $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
   endfunction

   // one full image, drains mixed in, then drains and surplus pixels until it is out
   task automatic run_image(input int unsigned style, input bit lead_drain);
      int unsigned total, base;
      total = clip(cfg_width, 1, STORE_COLS) * clip(cfg_height, 1, HEIGHT_CAP);
      base = $urandom_range(255);
      if (lead_drain) send_item(mat_pkg::MODE_DRAIN, rand_pixel());
      for (int unsigned i = 0; i < total; i++) begin
         if ($urandom_range(19) == 0 && style != 2)
            send_item(mat_pkg::MODE_DRAIN, rand_pixel());
         send_item(mat_pkg::MODE_PIXEL, make_pixel(style, base));
      end
      while (wr_row != 0 || wr_col != 0 || rd_row != 0 || rd_col != 0 || frame_in_done)
         send_item($urandom_range(3) == 0 ? mat_pkg::MODE_PIXEL : mat_pkg::MODE_DRAIN,
                   rand_pixel());
   endtask

   task automatic test_basic_modes();
      configure(5, 4, 2, 255, 0);
      run_image(2, 1);
      wait_idle();
      write_reg(mat_pkg::CSR_INVERT, mat_pkg::CSR_DATA_W'(1));
      run_image(0, 0);
      wait_idle();
      configure(6, 3, 3, 0, 0);
      run_image(1, 0);
      wait_idle();
   endtask

   task automatic test_window_edges();
      configure(16, 16, 16, 170, 1);
      run_image(0, 0);
      wait_idle();
      configure(1, 1, 1, 85, 0);
      run_image(2, 1);
      run_image(0, 0);
      wait_idle();
   endtask

   task automatic test_saturation();
      configure(0, 0, 0, 255, 0);
      run_image(0, 0);
      wait_idle();
      configure(2047, 1, 31, 200, 1);
      run_image(0, 0);
      wait_idle();
   endtask

   task automatic test_unused_index();
      configure(4, 4, 2, 99, 0);
      for (int unsigned idx = mat_pkg::CSR_INVERT + 1; idx <= CSR_LAST_INDEX; idx++)
         write_reg(mat_pkg::CSR_INDEX_W'(idx), '1);
      run_image(0, 0);
      wait_idle();
   endtask

   task automatic test_backpressure();
      configure(16, 4, 2, 255, 0);
      quiet = 1;
      @(negedge clock) hold_left = 800;
      run_image(0, 0);
      quiet = 0;
      wait_idle();
   endtask

   task automatic test_random_images();
      int unsigned start;
      start = items_sent;
      while (items_sent - start < 150) begin
         configure($urandom_range(3) == 0 ? $urandom_range(40, 1) : $urandom_range(12, 1),
                   $urandom_range(10, 1), $urandom_range(17), $urandom_range(255),
                   $urandom_range(1));
         quiet = ($urandom_range(4) == 0);
         run_image($urandom_range(2), $urandom_range(1));
         if ($urandom_range(1)) run_image($urandom_range(2), 0);
         quiet = 0;
         wait_idle();
      end
   endtask

   // receiver stall, with a long hold-off counted down at rising edges
   always @(posedge clock) if (hold_left > 0) hold_left <= hold_left - 1;

   always @(negedge clock) begin
      if (hold_left > 0) rsp_stall <= 1'b1;
      else if (quiet) rsp_stall <= 1'b0;
      else if ($urandom_range(19) == 0) rsp_stall <= 1'b1;
      else if ($urandom_range(3) == 0) rsp_stall <= ~rsp_stall;
      else rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin
      threshold_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            failures++;
            if (mismatches++ < 10)
               $display("unexpected result: level %0d last %0b",
                        rsp_result_pixel, rsp_last_of_image);
         end else begin
            want = expected_results.pop_front();
            if (rsp_result_pixel !== want.level || rsp_last_of_image !== want.last) begin
               failures++;
               if (mismatches++ < 10)
                  $display("result %0d: expected level %0d last %0b, got level %0d last %0b",
                           results_seen, want.level, want.last,
                           rsp_result_pixel, rsp_last_of_image);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_mode = mat_pkg::MODE_PIXEL; req_pixel = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0; csr_index = mat_pkg::CSR_IMAGE_WIDTH; csr_wdata = '0;
      hold_left = 0; quiet = 0;
      mismatches = 0; failures = 0; items_sent = 0; results_seen = 0; images_done = 0;
      wr_row = 0; wr_col = 0; rd_row = 0; rd_col = 0; frame_in_done = 0;
      cfg_width = mat_pkg::IMAGE_WIDTH_RESET; cfg_height = mat_pkg::IMAGE_HEIGHT_RESET;
      cfg_window = mat_pkg::WINDOW_SIZE_RESET; cfg_max = mat_pkg::MAX_VALUE_RESET;
      cfg_invert = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_basic_modes();
      test_window_edges();
      test_saturation();
      test_unused_index();
      test_backpressure();
      test_random_images();

      wait_idle();
      if (expected_results.size() != 0) failures++;
      $display("sent %0d items over %0d images, checked %0d thresholded pixels",
               items_sent, images_done, results_seen);
      $display("covered clipped windows, register saturation, inversion, drains and long stalls");
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d failures", failures);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
